// ----- hdl/ipv4rt_pkg.sv -----
`timescale 1ns / 1ps

package ipv4rt_pkg;

  localparam int RouteSlots = 64;
  localparam int SlotW      = $clog2(RouteSlots);
  localparam int CntW       = $clog2(RouteSlots + 1);
  localparam int LenW       = 6;
  localparam int AddrW      = 32;
  localparam int KeyW       = LenW + AddrW;
  localparam int DataW      = 43;

  localparam logic [1:0] ReqInsert = 2'd0;
  localparam logic [1:0] ReqDelete = 2'd1;
  localparam logic [1:0] ReqExact  = 2'd2;
  localparam logic [1:0] ReqLpm    = 2'd3;

  localparam logic [1:0] StatOk       = 2'd0;
  localparam logic [1:0] StatNotFound = 2'd1;
  localparam logic [1:0] StatFull     = 2'd2;

  localparam logic [LenW-1:0] MaxLen = LenW'(AddrW);

  function automatic logic [AddrW-1:0] prefix_mask(input logic [LenW-1:0] len);
    logic [AddrW-1:0] m;
    m = '0;
    if (len != '0) begin
      m = {AddrW{1'b1}} << (MaxLen - len);
    end
    return m;
  endfunction

endpackage

// ----- hdl/ipv4_route_table_lpm.sv -----
`timescale 1ns / 1ps

// Routing table with insert, delete, exact lookup and longest-prefix lookup.
// Every request walks the key memory one slot per cycle through one shared
// compare unit; a lookup that hits then reads the route data in an extra
// read state. One request is in flight at a time: in_stall_o is high from
// the transfer of a request until its result is transferred, which the
// output can stall. Valid bits are cleared by reset; no clearing pass is
// needed.
module ipv4_route_table_lpm
  import ipv4rt_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        req_type_i,
  input  logic [AddrW-1:0]  address_i,
  input  logic [LenW-1:0]   prefix_len_i,
  input  logic [AddrW-1:0]  gateway_i,
  input  logic              gateway_valid_i,
  input  logic [7:0]        out_interface_i,
  input  logic              out_interface_valid_i,
  input  logic              direct_route_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        status_o,
  output logic [LenW-1:0]   match_len_o,
  output logic [AddrW-1:0]  match_prefix_o,
  output logic [AddrW-1:0]  next_hop_o,
  output logic              next_hop_valid_o,
  output logic [7:0]        egress_index_o,
  output logic              egress_valid_o,
  output logic              is_direct_route_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StScan = 3'd1;
  localparam logic [2:0] StDone = 3'd2;
  localparam logic [2:0] StRead = 3'd3;
  localparam logic [2:0] StOut  = 3'd4;

  localparam logic [CntW-1:0] LastCnt = CntW'(RouteSlots);

  logic [2:0]             state_q;
  logic [CntW-1:0]        cnt_q;
  logic [RouteSlots-1:0]  valid_q;

  logic [1:0]             req_q;
  logic [AddrW-1:0]       addr_q;
  logic [LenW-1:0]        len_q;
  logic [AddrW-1:0]       prefix_q;
  logic [DataW-1:0]       wdata_q;

  logic [KeyW-1:0]        key_mem [RouteSlots];
  logic [DataW-1:0]       data_mem [RouteSlots];
  logic [KeyW-1:0]        key_rd_q;
  logic [DataW-1:0]       data_rd_q;
  logic [SlotW-1:0]       rd_slot_q;
  logic                   rd_vld_q;

  logic                   hit_q;
  logic [SlotW-1:0]       hit_slot_q;
  logic [LenW-1:0]        best_len_q;
  logic                   free_q;
  logic [SlotW-1:0]       free_slot_q;

  logic [1:0]             status_q;
  logic [LenW-1:0]        mlen_q;
  logic [AddrW-1:0]       mprefix_q;
  logic [DataW-1:0]       mdata_q;

  logic                   in_xfer;
  logic                   out_xfer;
  logic [LenW-1:0]        len_sat;
  logic [LenW-1:0]        k_len;
  logic [AddrW-1:0]       k_prefix;
  logic                   k_valid;
  logic                   exact_hit;
  logic                   lpm_hit;
  logic                   key_we;
  logic [SlotW-1:0]       wr_slot;
  logic                   lookup_hit;

  assign in_stall_o = (state_q != StIdle);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_xfer   = out_valid_o && !out_stall_i;
  assign len_sat    = (prefix_len_i > MaxLen) ? MaxLen : prefix_len_i;

  assign k_len     = key_rd_q[KeyW-1:AddrW];
  assign k_prefix  = key_rd_q[AddrW-1:0];
  assign k_valid   = rd_vld_q && valid_q[rd_slot_q];
  assign exact_hit = k_valid && (k_len == len_q) && (k_prefix == prefix_q);
  assign lpm_hit   = k_valid && (k_len <= MaxLen)
                   && ((addr_q & prefix_mask(k_len)) == k_prefix)
                   && (!hit_q || (k_len > best_len_q));

  assign key_we     = (state_q == StDone) && (req_q == ReqInsert) && (hit_q || free_q);
  assign wr_slot    = hit_q ? hit_slot_q : free_slot_q;
  assign lookup_hit = hit_q && ((req_q == ReqExact) || (req_q == ReqLpm));

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[wr_slot]  <= {len_q, prefix_q};
      data_mem[wr_slot] <= wdata_q;
    end
    key_rd_q  <= key_mem[cnt_q[SlotW-1:0]];
    data_rd_q <= data_mem[hit_slot_q];
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      req_q    <= req_type_i;
      addr_q   <= address_i;
      len_q    <= len_sat;
      prefix_q <= address_i & prefix_mask(len_sat);
      wdata_q  <= {gateway_i, gateway_valid_i, out_interface_i,
                   out_interface_valid_i, direct_route_i};
    end
    rd_slot_q <= cnt_q[SlotW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      valid_q     <= '0;
      rd_vld_q    <= 1'b0;
      hit_q       <= 1'b0;
      hit_slot_q  <= '0;
      best_len_q  <= '0;
      free_q      <= 1'b0;
      free_slot_q <= '0;
      out_valid_o <= 1'b0;
      status_q    <= StatOk;
      mlen_q      <= '0;
      mprefix_q   <= '0;
      mdata_q     <= '0;
    end else begin
      rd_vld_q <= (state_q == StScan) && (cnt_q != LastCnt);
      case (state_q)
        StIdle: begin
          if (in_xfer) begin
            cnt_q      <= '0;
            hit_q      <= 1'b0;
            free_q     <= 1'b0;
            best_len_q <= '0;
            state_q    <= StScan;
          end
        end
        StScan: begin
          if (cnt_q != LastCnt) begin
            cnt_q <= cnt_q + CntW'(1);
          end else begin
            state_q <= StDone;
          end
          if (rd_vld_q && !valid_q[rd_slot_q] && !free_q) begin
            free_q      <= 1'b1;
            free_slot_q <= rd_slot_q;
          end
          if (req_q == ReqLpm) begin
            if (lpm_hit) begin
              hit_q      <= 1'b1;
              hit_slot_q <= rd_slot_q;
              best_len_q <= k_len;
              mlen_q     <= k_len;
              mprefix_q  <= k_prefix;
            end
          end else if (exact_hit && !hit_q) begin
            hit_q      <= 1'b1;
            hit_slot_q <= rd_slot_q;
            mlen_q     <= k_len;
            mprefix_q  <= k_prefix;
          end
        end
        StDone: begin
          if (lookup_hit) begin
            state_q <= StRead;
          end else begin
            mlen_q      <= '0;
            mprefix_q   <= '0;
            mdata_q     <= '0;
            out_valid_o <= 1'b1;
            state_q     <= StOut;
            case (req_q)
              ReqInsert: begin
                status_q <= key_we ? StatOk : StatFull;
                if (key_we) begin
                  valid_q[wr_slot] <= 1'b1;
                end
              end
              ReqDelete: begin
                status_q <= hit_q ? StatOk : StatNotFound;
                if (hit_q) begin
                  valid_q[hit_slot_q] <= 1'b0;
                end
              end
              default: status_q <= StatNotFound;
            endcase
          end
        end
        StRead: begin
          status_q    <= StatOk;
          mdata_q     <= data_rd_q;
          out_valid_o <= 1'b1;
          state_q     <= StOut;
        end
        StOut: begin
          if (out_xfer) begin
            out_valid_o <= 1'b0;
            state_q     <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign status_o          = status_q;
  assign match_len_o       = mlen_q;
  assign match_prefix_o    = mprefix_q;
  assign next_hop_o        = mdata_q[42:11];
  assign next_hop_valid_o  = mdata_q[10];
  assign egress_index_o    = mdata_q[9:2];
  assign egress_valid_o    = mdata_q[1];
  assign is_direct_route_o = mdata_q[0];

  a_full_means_all_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_q == StatFull) |-> (&valid_q))
    else $error("table full reported with a free slot");

  a_hit_slot_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDone && hit_q) |-> valid_q[hit_slot_q])
    else $error("matched slot is not valid");

  a_one_slot_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StDone) |=> (valid_q == $past(valid_q)))
    else $error("valid bits changed outside the commit cycle");

  a_scan_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q == StScan && cnt_q == '0 && !hit_q && !free_q))
    else $error("scan did not start cleanly after a request transfer");

endmodule
